// ===== design/key_matrix_scan_debounce_core_macros.svh =====
// ============================================================================
// Key matrix scan debounce core - assertion macros
// Shared concurrent assertion wrappers, clocked on aclk, off during reset.
// ============================================================================
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_CORE_MACROS_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_CORE_MACROS_SVH

// Same-cycle implication
`define KMSD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define KMSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/kmsd_pkg.sv =====
// ============================================================================
// Key matrix scan debounce package
// Shared types and constants: key state entry, event codes, port widths.
// ============================================================================
package kmsd_pkg;

    // Stream payload widths (byte padded)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // Output field widths
    localparam int ROW_OUT_W = 3;
    localparam int COL_OUT_W = 5;
    localparam int EV_W      = 2;

    // Configuration register
    localparam int          DEB_W          = 8;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd5;

    // Event codes
    typedef enum logic [EV_W-1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_t;

    // Per-key stored state: debounced level and time of last accepted change
    typedef struct packed {
        logic        level;
        logic [31:0] stamp;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{level: 1'b1, stamp: 32'd0};

endpackage

// ===== design/key_matrix_scan_debounce_core.sv =====
// ============================================================================
// Key matrix scan debounce core
// Per-key debounce of a column-major key matrix scan, state held in a RAM.
// ============================================================================
// Usage:
//   s_axis_*: one key sample per transfer, for the key at the current scan
//     position (row advances every transfer, column when the row wraps).
//   m_axis_*: exactly one result per sample: row, column and event code
//     (none, press, release).
//   cfg_*: write port for debounce_ms; write only while the core is idle.
// Throughput: one sample per cycle while the output is not stalled. A
//   sample reaches m_axis_tvalid through the read stage, which reads the key
//   state RAM, followed by the output register.
// Reset: scan position returns to row 0, column 0, debounce_ms to 5. The
//   RAM is not cleared; during the first pass of the scan each key reads as
//   released with change time 0, so no clearing pass is needed.
// Stall: when m_axis_tready is low the output and the read stage hold, and
//   s_axis_tready drops once both are full.
// ============================================================================
`include "key_matrix_scan_debounce_core_macros.svh"

module key_matrix_scan_debounce_core #(
    parameter int ROWS = 6,
    parameter int COLS = 17
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // [0] level, [32:1] now_ms, [39:33] zero
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kmsd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] key_row, [7:3] key_col, [9:8] event_res, [15:10] zero
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [kmsd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // debounce_ms write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kmsd_pkg::DEB_W-1:0]       cfg_data
);
    import kmsd_pkg::*;

    localparam int KEYS  = ROWS * COLS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

    // ------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------
    logic [DEB_W-1:0] debounce_reg;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             first_pass_reg;
    logic             scan_wrap;

    logic             s_acc;
    logic             s1_adv;

    logic             s1_valid_reg;
    logic             s1_level_reg;
    logic [31:0]      s1_now_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_fresh_reg;
    logic             s1_fwd_reg;
    entry_t           s1_fwd_data_reg;
    entry_t           rd_data_reg;

    entry_t           cur_entry;
    entry_t           wr_data;
    logic [31:0]      elapsed;
    logic             change;
    event_t           ev;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    entry_t key_mem [KEYS];

    // ------------------------------------------------------------------
    // Handshakes; no transfer is taken while in reset
    // ------------------------------------------------------------------
    assign s1_adv        = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = aresetn && (!s1_valid_reg || s1_adv);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = aresetn;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            debounce_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Scan position: row first, then column; flat index kept alongside
    // ------------------------------------------------------------------
    always_comb begin
        scan_wrap = 1'b0;
        row_next  = row_reg + ROW_W'(1);
        col_next  = col_reg;
        idx_next  = idx_reg + IDX_W'(1);
        if (row_reg == ROW_LAST) begin
            row_next = '0;
            if (col_reg == COL_LAST) begin
                col_next  = '0;
                idx_next  = '0;
                scan_wrap = 1'b1;
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= '0;
            col_reg        <= '0;
            idx_reg        <= '0;
            first_pass_reg <= 1'b1;
        end else if (s_acc) begin
            row_reg <= row_next;
            col_reg <= col_next;
            idx_reg <= idx_next;
            if (scan_wrap) begin
                first_pass_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Key state RAM: read at accept, write back from the read stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rd_data_reg <= key_mem[idx_reg];
        end
        if (s1_adv) begin
            key_mem[s1_idx_reg] <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Read stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_level_reg    <= s_axis_tdata[0];
            s1_now_reg      <= s_axis_tdata[32:1];
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_idx_reg      <= idx_reg;
            s1_fresh_reg    <= first_pass_reg;
            // same key written back at this edge: RAM read returns stale data
            s1_fwd_reg      <= s1_adv && (s1_idx_reg == idx_reg);
            s1_fwd_data_reg <= wr_data;
        end
    end

    // Entry select: forwarded write, then unwritten key, then RAM
    always_comb begin
        priority if (s1_fwd_reg) begin
            cur_entry = s1_fwd_data_reg;
        end else if (s1_fresh_reg) begin
            cur_entry = ENTRY_RESET;
        end else begin
            cur_entry = rd_data_reg;
        end
    end

    // Debounce decision, elapsed time wraps modulo 2^32
    always_comb begin
        elapsed = s1_now_reg - cur_entry.stamp;
        change  = (s1_level_reg != cur_entry.level) &&
                  (elapsed >= {{(32 - DEB_W){1'b0}}, debounce_reg});
        wr_data = cur_entry;
        ev      = EV_NONE;
        if (change) begin
            wr_data.level = s1_level_reg;
            wr_data.stamp = s1_now_reg;
            ev            = s1_level_reg ? EV_RELEASE : EV_PRESS;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= {(M_TDATA_W - EV_W - COL_OUT_W - ROW_OUT_W)'(0), ev,
                           COL_OUT_W'(s1_col_reg), ROW_OUT_W'(s1_row_reg)};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `KMSD_ASSERT_IMPL(a_idx_match, 1'b1, 32'(idx_reg) == 32'(col_reg) * ROWS + 32'(row_reg), "scan index out of step with row and column")
    `KMSD_ASSERT_NEXT(a_first_pass_once, !first_pass_reg, !first_pass_reg, "first pass flag set again after scan wrap")
    `KMSD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && m_valid_reg && !m_axis_tready, s1_valid_reg, "read stage lost a sample while output stalled")

endmodule
